>>> rtl/chunked_stage_crc_verifier_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunked stage CRC verifier
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_STAGE_CRC_VERIFIER_UNIT_ASSERT_SVH
`define CHUNKED_STAGE_CRC_VERIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CSCV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cscv assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CSCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cscv assertion failed");

`endif

>>> rtl/cscv_pkg.sv
// ----------------------------------------------------------------------------
// cscv_pkg
// Types, constants and the CRC step shared by the verifier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cscv_pkg;

    // Store and chunk sizing
    localparam int STORE_BYTES = 256;
    localparam int IDX_W       = $clog2(STORE_BYTES);
    localparam int CHUNK_MAX   = 24;
    localparam int BP_W        = 5;
    localparam logic [8:0] STORE_LIMIT = 9'(STORE_BYTES);

    // Command queue sizing
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Header and commit payload sizes
    localparam logic [16:0] HDR_PLEN_BASE = 17'd3;
    localparam logic [15:0] COMMIT_PLEN   = 16'd4;

    // Operation codes
    localparam logic [2:0] OP_HEADER = 3'd0;
    localparam logic [2:0] OP_DATA   = 3'd1;
    localparam logic [2:0] OP_COMMIT = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_INVALID   = 3'd2,
        ST_DENIED    = 3'd3,
        ST_SKIPPED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CMD_HEADER,
        CMD_DATA,
        CMD_COMMIT,
        CMD_READ,
        CMD_OTHER
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  transaction_id;
        logic [7:0]  start_offset;
        logic [7:0]  length;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic [15:0] target_crc;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  read_data;
        logic [15:0] computed_crc;
    } result_t;

    // Classified command passed from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        status_t     pre_status;
        logic        len_bad;
        logic [7:0]  tid;
        logic [7:0]  offset;
        logic [7:0]  length;
        logic [7:0]  data;
        logic [15:0] ecrc;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cscv_front.sv
// ----------------------------------------------------------------------------
// cscv_front
// Decodes an incoming request and runs the state-free format checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cscv_front (
    input  wire cscv_pkg::item_t item,
    output cscv_pkg::cmd_t       cmd
);

    logic [8:0]  span_end;
    logic [16:0] hdr_plen;

    // Chunk end and expected header payload size
    assign span_end = {1'b0, item.start_offset} + {1'b0, item.length};
    assign hdr_plen = {9'd0, item.length} + cscv_pkg::HDR_PLEN_BASE;

    // Classify the request and precompute its format status
    always_comb
    begin
        cmd.tid        = item.transaction_id;
        cmd.offset     = item.start_offset;
        cmd.length     = item.length;
        cmd.data       = item.data_byte;
        cmd.ecrc       = item.target_crc;
        cmd.len_bad    = 1'b0;
        cmd.pre_status = cscv_pkg::ST_OK;
        cmd.kind       = cscv_pkg::CMD_OTHER;
        unique case (item.operation)
            cscv_pkg::OP_HEADER:
            begin
                cmd.kind = cscv_pkg::CMD_HEADER;
                if (item.payload_length < 16'(cscv_pkg::HDR_PLEN_BASE))
                    cmd.pre_status = cscv_pkg::ST_MALFORMED;
                else if (item.length == 8'd0
                         || item.length > 8'(cscv_pkg::CHUNK_MAX)
                         || {1'b0, item.payload_length} != hdr_plen
                         || span_end >= cscv_pkg::STORE_LIMIT)
                    cmd.pre_status = cscv_pkg::ST_INVALID;
            end
            cscv_pkg::OP_DATA:
            begin
                cmd.kind = cscv_pkg::CMD_DATA;
            end
            cscv_pkg::OP_COMMIT:
            begin
                cmd.kind = cscv_pkg::CMD_COMMIT;
                if (item.payload_length != cscv_pkg::COMMIT_PLEN)
                    cmd.pre_status = cscv_pkg::ST_MALFORMED;
                cmd.len_bad = (item.length == 8'd0)
                              || ({1'b0, item.length} >= cscv_pkg::STORE_LIMIT);
            end
            cscv_pkg::OP_READ:
            begin
                cmd.kind = cscv_pkg::CMD_READ;
                if ({1'b0, item.start_offset} >= cscv_pkg::STORE_LIMIT)
                    cmd.pre_status = cscv_pkg::ST_INVALID;
            end
            default:
            begin
                cmd.kind       = cscv_pkg::CMD_OTHER;
                cmd.pre_status = cscv_pkg::ST_SKIPPED;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/cscv_queue.sv
// ----------------------------------------------------------------------------
// cscv_queue
// Short command queue between the front decoder and the back engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cscv_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   wr_en,
    input  wire cscv_pkg::cmd_t   wr_cmd,
    input  wire                   rd_en,
    output cscv_pkg::cmd_t        rd_cmd,
    output cscv_pkg::q_status_t   stat
);

    cscv_pkg::cmd_t                entry_reg [cscv_pkg::Q_DEPTH];
    logic [cscv_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [cscv_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [cscv_pkg::Q_PTR_W:0]    count_reg;
    logic                          do_wr;
    logic                          do_rd;

    assign stat.full  = (count_reg == (cscv_pkg::Q_PTR_W+1)'(cscv_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_cmd     = entry_reg[rd_ptr_reg];

    // Store an incoming command
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    // Advance pointers and track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cscv_back.sv
// ----------------------------------------------------------------------------
// cscv_back
// Executes commands against the stage: byte store, receive map, commit walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cscv_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire cscv_pkg::q_status_t q_stat,
    input  wire cscv_pkg::cmd_t      cmd,
    output logic                     cmd_pop,
    input  wire                      pop,
    output logic                     res_valid,
    output cscv_pkg::result_t        result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_DRAIN
    } state_t;

    // Byte store, single port with registered read
    logic [7:0]                     mem [cscv_pkg::STORE_BYTES];
    logic [7:0]                     mem_q;
    logic                           mem_we;
    logic                           mem_re;
    logic [7:0]                     mem_addr;
    logic [7:0]                     mem_wdata;

    state_t                         state_reg, state_next;
    logic                           res_valid_reg, res_valid_next;
    cscv_pkg::result_t              result_reg, result_next;
    logic                           active_reg, active_next;
    logic [7:0]                     stid_reg, stid_next;
    logic [cscv_pkg::STORE_BYTES-1:0] map_reg, map_next;
    logic [7:0]                     wi_reg, wi_next;
    logic [cscv_pkg::BP_W-1:0]      pending_reg, pending_next;
    logic [7:0]                     cnt_reg, cnt_next;
    logic [7:0]                     last_reg, last_next;
    logic                           hole_reg, hole_next;
    logic                           rdv_reg, rdv_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [15:0]                    ecrc_reg, ecrc_next;

    logic                           slot_free;
    logic                           take;
    logic                           tid_match;
    logic [15:0]                    crc_step;
    cscv_pkg::status_t              st;

    assign res_valid = res_valid_reg;
    assign result    = result_reg;
    assign slot_free = !res_valid_reg || pop;
    assign take      = (state_reg == S_IDLE) && !q_stat.empty
                       && (cmd.kind == cscv_pkg::CMD_DATA || slot_free);
    assign cmd_pop   = take;
    assign tid_match = active_reg && (stid_reg == cmd.tid);
    assign crc_step  = cscv_pkg::crc_byte(crc_reg, mem_q);

    // Byte store access
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr[cscv_pkg::IDX_W-1:0]] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_addr[cscv_pkg::IDX_W-1:0]];
    end

    // Command execution and next state
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !pop;
        result_next    = result_reg;
        active_next    = active_reg;
        stid_next      = stid_reg;
        map_next       = map_reg;
        wi_next        = wi_reg;
        pending_next   = pending_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        hole_next      = hole_reg;
        rdv_next       = 1'b0;
        crc_next       = rdv_reg ? crc_step : crc_reg;
        ecrc_next      = ecrc_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = wi_reg;
        mem_wdata      = cmd.data;
        st             = cmd.pre_status;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    // any request but a data byte drops the rest of a chunk
                    if (cmd.kind != cscv_pkg::CMD_DATA)
                        pending_next = '0;
                    unique case (cmd.kind)
                        cscv_pkg::CMD_DATA:
                        begin
                            if (pending_reg != '0)
                            begin
                                if ({1'b0, wi_reg} < cscv_pkg::STORE_LIMIT)
                                begin
                                    mem_we = 1'b1;
                                    map_next[wi_reg[cscv_pkg::IDX_W-1:0]] = 1'b1;
                                end
                                wi_next      = wi_reg + 8'd1;
                                pending_next = pending_reg - 1'b1;
                            end
                        end
                        cscv_pkg::CMD_HEADER:
                        begin
                            if (st == cscv_pkg::ST_OK && !tid_match)
                            begin
                                if (cmd.offset != 8'd0)
                                    st = cscv_pkg::ST_DENIED;
                                else
                                begin
                                    map_next    = '0;
                                    active_next = 1'b1;
                                    stid_next   = cmd.tid;
                                end
                            end
                            if (st == cscv_pkg::ST_OK)
                            begin
                                wi_next      = cmd.offset;
                                pending_next = cmd.length[cscv_pkg::BP_W-1:0];
                            end
                            res_valid_next = 1'b1;
                            result_next    = '{status: st, read_data: 8'd0,
                                               computed_crc: 16'd0};
                        end
                        cscv_pkg::CMD_COMMIT:
                        begin
                            if (st != cscv_pkg::ST_OK || !tid_match)
                            begin
                                if (st == cscv_pkg::ST_OK)
                                    st = cscv_pkg::ST_DENIED;
                                res_valid_next = 1'b1;
                                result_next    = '{status: st, read_data: 8'd0,
                                                   computed_crc: 16'd0};
                            end
                            else if (cmd.len_bad)
                            begin
                                active_next    = 1'b0;
                                stid_next      = 8'd0;
                                map_next       = '0;
                                res_valid_next = 1'b1;
                                result_next    = '{status: cscv_pkg::ST_INVALID,
                                                   read_data: 8'd0,
                                                   computed_crc: 16'd0};
                            end
                            else
                            begin
                                // start the walk over bytes below the total length
                                cnt_next   = 8'd0;
                                last_next  = cmd.length - 8'd1;
                                hole_next  = 1'b0;
                                crc_next   = cscv_pkg::CRC_INIT;
                                ecrc_next  = cmd.ecrc;
                                state_next = S_WALK;
                            end
                        end
                        cscv_pkg::CMD_READ:
                        begin
                            if (st != cscv_pkg::ST_OK)
                            begin
                                res_valid_next = 1'b1;
                                result_next    = '{status: st, read_data: 8'd0,
                                                   computed_crc: 16'd0};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_addr   = cmd.offset;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            result_next    = '{status: cscv_pkg::ST_SKIPPED,
                                               read_data: 8'd0, computed_crc: 16'd0};
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_valid_next = 1'b1;
                result_next    = '{status: cscv_pkg::ST_OK, read_data: mem_q,
                                   computed_crc: 16'd0};
                state_next     = S_IDLE;
            end
            S_WALK:
            begin
                // fetch one byte and check its receive bit
                mem_re   = 1'b1;
                mem_addr = cnt_reg;
                rdv_next = 1'b1;
                if (!map_reg[cnt_reg[cscv_pkg::IDX_W-1:0]])
                    hole_next = 1'b1;
                if (cnt_reg == last_reg)
                    state_next = S_DRAIN;
                else
                    cnt_next = cnt_reg + 8'd1;
            end
            S_DRAIN:
            begin
                // fold in the last byte, report and clear the stage
                res_valid_next = 1'b1;
                if (hole_reg)
                    result_next = '{status: cscv_pkg::ST_DENIED, read_data: 8'd0,
                                    computed_crc: 16'd0};
                else if (crc_step == ecrc_reg)
                    result_next = '{status: cscv_pkg::ST_OK, read_data: 8'd0,
                                    computed_crc: crc_step};
                else
                    result_next = '{status: cscv_pkg::ST_INVALID, read_data: 8'd0,
                                    computed_crc: crc_step};
                active_next = 1'b0;
                stid_next   = 8'd0;
                map_next    = '0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, stage registers and the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            result_reg    <= '0;
            active_reg    <= 1'b0;
            stid_reg      <= 8'd0;
            map_reg       <= '0;
            wi_reg        <= 8'd0;
            pending_reg   <= '0;
            cnt_reg       <= 8'd0;
            last_reg      <= 8'd0;
            hole_reg      <= 1'b0;
            rdv_reg       <= 1'b0;
            crc_reg       <= cscv_pkg::CRC_INIT;
            ecrc_reg      <= 16'd0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            result_reg    <= result_next;
            active_reg    <= active_next;
            stid_reg      <= stid_next;
            map_reg       <= map_next;
            wi_reg        <= wi_next;
            pending_reg   <= pending_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            hole_reg      <= hole_next;
            rdv_reg       <= rdv_next;
            crc_reg       <= crc_next;
            ecrc_reg      <= ecrc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/chunked_stage_crc_verifier_unit.sv
// ----------------------------------------------------------------------------
// chunked_stage_crc_verifier_unit
// Reassembles chunked transfers into a byte store and verifies them by CRC.
//
// Channel   Direction  Handshake         Payload
// request   in         push / full       item   (cscv_pkg::item_t)
// result    out        empty / pop       result (cscv_pkg::result_t)
//
// A data byte gives no result; a header, an other command or a rejected read or
// commit answers straight from the idle state, a read from the S_READ state.
// A commit that reaches the check walks the byte store through its single
// read port, one byte a cycle, and answers from the S_DRAIN state.
// A four-entry command queue keeps requests flowing while the back engine walks.
// The result register holds one result; the engine waits for it to be popped
// before starting a request that answers. Reset clears the receive map at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chunked_stage_crc_verifier_unit (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       push,
    output logic                      full,
    input  wire cscv_pkg::item_t      item,
    output logic                      empty,
    input  wire                       pop,
    output cscv_pkg::result_t         result
);

    cscv_pkg::cmd_t      front_cmd;
    cscv_pkg::cmd_t      back_cmd;
    cscv_pkg::q_status_t q_stat;
    logic                cmd_pop;
    logic                res_valid;

    // Decode incoming requests
    cscv_front u_front (
        .item (item),
        .cmd  (front_cmd)
    );

    // Buffer decoded commands
    cscv_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_cmd (front_cmd),
        .rd_en  (cmd_pop),
        .rd_cmd (back_cmd),
        .stat   (q_stat)
    );

    // Execute commands
    cscv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .res_valid (res_valid),
        .result    (result)
    );

    assign full  = q_stat.full;
    assign empty = !res_valid;

endmodule

`default_nettype wire

>>> rtl/cscv_checker.sv
// ----------------------------------------------------------------------------
// cscv_checker
// Port-level checks on the result channel of the verifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chunked_stage_crc_verifier_unit_assert.svh"

module cscv_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    empty,
    input wire                    pop,
    input wire cscv_pkg::result_t result
);

    // A waiting result stays until popped
    `CSCV_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(result))

    // Status codes stay within the defined set
    `CSCV_ASSERT_NOW(a_status_range, clk, rst_n, !empty, result.status <= cscv_pkg::ST_SKIPPED)

    // Read data only shows on a successful read
    `CSCV_ASSERT_NOW(a_rdata_ok, clk, rst_n, !empty && result.read_data != 8'd0, result.status == cscv_pkg::ST_OK)

    // A CRC is reported only by a commit that reached the compare
    `CSCV_ASSERT_NOW(a_crc_status, clk, rst_n, !empty && result.computed_crc != 16'd0, result.status == cscv_pkg::ST_OK || result.status == cscv_pkg::ST_INVALID)

endmodule

bind chunked_stage_crc_verifier_unit cscv_checker u_cscv_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

>>> dv/stage_crc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_crc_checker
// Watches the request and result queues of the chunked stage CRC verifier,
// predicts the result of every accepted request from its own copy of the
// stage and compares each popped result field by field, oldest first.
// ----------------------------------------------------------------------------
module stage_crc_checker (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  wire               full,
    input  cscv_pkg::item_t   item,
    input  wire               empty,
    input  wire               pop,
    input  cscv_pkg::result_t result,
    output int                errors,
    output int                awaiting
);
    import cscv_pkg::*;

    // Predicted stage
    logic        stage_open = 1'b0;
    logic [7:0]  stage_tag  = '0;
    logic [7:0]  stage_store [0:255];
    logic [255:0] seen      = '0;
    logic [7:0]  fill_ptr   = '0;
    logic [4:0]  chunk_left = '0;

    result_t due_results[$];
    int      fail_count = 0;
    int      due_count  = 0;

    assign errors   = fail_count;
    assign awaiting = due_count;

    // Drop the staged transaction; the byte store keeps its contents
    function automatic void drop_stage();
        stage_open = 1'b0;
        stage_tag  = '0;
        seen       = '0;
        chunk_left = '0;
    endfunction

    // CRC-16/CCITT-FALSE over the first count bytes of the store
    function automatic logic [15:0] store_crc(input int count);
        logic [15:0] c;
        int          i;
        int          b;
        c = CRC_INIT;
        for (i = 0; i < count; i++) begin
            c = c ^ {stage_store[i], 8'h00};
            for (b = 0; b < 8; b++)
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Advance the stage by one request and give its result, if it has one
    function automatic void stage_outcome(input item_t req, output bit answers,
                                          output result_t res);
        status_t     st;
        logic [7:0]  rd;
        logic [15:0] crc;
        bit          covered;
        int          i;
        st      = ST_OK;
        rd      = '0;
        crc     = '0;
        res     = '0;
        answers = 1'b0;

        // Store a data byte while the chunk still expects some
        if (req.operation == OP_DATA) begin
            if (chunk_left != 0) begin
                stage_store[fill_ptr] = req.data_byte;
                seen[fill_ptr]        = 1'b1;
                fill_ptr              = fill_ptr + 8'd1;
                chunk_left            = chunk_left - 5'd1;
            end
            return;
        end

        // Any other request drops the rest of an unfinished chunk
        answers    = 1'b1;
        chunk_left = '0;
        case (req.operation)
            OP_HEADER: begin
                if (req.payload_length < 16'(HDR_PLEN_BASE))
                    st = ST_MALFORMED;
                else if (req.length == 0 || int'(req.length) > CHUNK_MAX ||
                         int'(req.payload_length) != int'(HDR_PLEN_BASE) + int'(req.length) ||
                         int'(req.start_offset) + int'(req.length) >= STORE_BYTES)
                    st = ST_INVALID;
                else if (!stage_open || stage_tag != req.transaction_id) begin
                    if (req.start_offset != 0)
                        st = ST_DENIED;
                    else begin
                        drop_stage();
                        stage_open = 1'b1;
                        stage_tag  = req.transaction_id;
                    end
                end
                if (st == ST_OK) begin
                    fill_ptr   = req.start_offset;
                    chunk_left = req.length[4:0];
                end
            end
            OP_COMMIT: begin
                if (req.payload_length != COMMIT_PLEN)
                    st = ST_MALFORMED;
                else if (!stage_open || stage_tag != req.transaction_id)
                    st = ST_DENIED;
                else if (req.length == 0 || int'(req.length) >= STORE_BYTES) begin
                    drop_stage();
                    st = ST_INVALID;
                end else begin
                    covered = 1'b1;
                    for (i = 0; i < int'(req.length); i++)
                        if (!seen[i])
                            covered = 1'b0;
                    if (!covered)
                        st = ST_DENIED;
                    else begin
                        crc = store_crc(int'(req.length));
                        st  = (crc == req.target_crc) ? ST_OK : ST_INVALID;
                    end
                    drop_stage();
                end
            end
            OP_READ: begin
                if (int'(req.start_offset) < STORE_BYTES)
                    rd = stage_store[req.start_offset];
                else
                    st = ST_INVALID;
            end
            default: st = ST_SKIPPED;
        endcase
        res.status       = st;
        res.read_data    = rd;
        res.computed_crc = crc;
    endfunction

    // Check popped results first, then predict the request taken at this edge
    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        result_t res;
        bit      answers;
        if (!rst_n) begin
            due_results.delete();
            drop_stage();
            fill_ptr = '0;
            due_count <= 0;
        end else begin
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    fail_count++;
                    $error("result popped with no request waiting: status %0d",
                           result.status);
                end else begin
                    want = due_results.pop_front();
                    if (result.status !== want.status) begin
                        fail_count++;
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, result.status);
                    end
                    if (result.read_data !== want.read_data) begin
                        fail_count++;
                        $error("read_data mismatch: expected %0h, actual %0h",
                               want.read_data, result.read_data);
                    end
                    if (result.computed_crc !== want.computed_crc) begin
                        fail_count++;
                        $error("computed_crc mismatch: expected %0h, actual %0h",
                               want.computed_crc, result.computed_crc);
                    end
                end
            end
            if (push && !full) begin
                stage_outcome(item, answers, res);
                if (answers)
                    due_results.push_back(res);
            end
            due_count <= due_results.size();
        end
    end

endmodule

>>> dv/tb_chunked_stage_crc_verifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunked_stage_crc_verifier_unit
// Drives chunked transfers, reads, malformed and stray requests into the
// verifier under four idle and stall patterns; the stage checker predicts
// and compares every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_chunked_stage_crc_verifier_unit;
    import cscv_pkg::*;

    localparam logic [2:0] OP_OTHER    = 3'd4;
    localparam int         ITEM_TARGET = 450;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         DRAIN_WAIT  = 300;
    localparam int         LAST_ADDR   = 254;  // highest index a chunk can reach

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    push       = 1'b0;
    logic    pop        = 1'b0;
    item_t   item_in    = '0;
    logic    full;
    logic    empty;
    result_t result_out;

    int errors;
    int awaiting;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int sent_count    = 0;
    int cycle_count   = 0;

    // Bytes sent for the current transfer, for the commit CRC
    logic [7:0] image [0:255];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    chunked_stage_crc_verifier_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item_in),
        .empty  (empty),
        .pop    (pop),
        .result (result_out)
    );

    stage_crc_checker stage_watch (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item_in),
        .empty    (empty),
        .pop      (pop),
        .result   (result_out),
        .errors   (errors),
        .awaiting (awaiting)
    );

    // Stall the result side at the phase rate
    always @(posedge clk) begin
        if (rst_n)
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic item_t junk_item();
        item_t r;
        r.operation      = 3'($urandom_range(7));
        r.transaction_id = 8'($urandom_range(255));
        r.start_offset   = 8'($urandom_range(255));
        r.length         = 8'($urandom_range(255));
        r.payload_length = 16'($urandom_range(65535));
        r.data_byte      = 8'($urandom_range(255));
        r.target_crc     = 16'($urandom_range(65535));
        return r;
    endfunction

    function automatic logic [15:0] hdr_plen(input logic [7:0] len);
        return 16'(HDR_PLEN_BASE) + 16'(len);
    endfunction

    // CRC-16/CCITT-FALSE over the bytes sent so far
    function automatic logic [15:0] image_crc(input int count);
        logic [15:0] c;
        int          i;
        int          b;
        c = CRC_INIT;
        for (i = 0; i < count; i++) begin
            c = c ^ {image[i], 8'h00};
            for (b = 0; b < 8; b++)
                c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Idle at the phase rate, then hold the request until it is taken
    task automatic send_request(input item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        item_in <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_count++;
    endtask

    // Hold off until every predicted result has been popped
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic send_header(input logic [7:0] tid, input logic [7:0] off,
                               input logic [7:0] len, input logic [15:0] plen);
        item_t r;
        r                = junk_item();
        r.operation      = OP_HEADER;
        r.transaction_id = tid;
        r.start_offset   = off;
        r.length         = len;
        r.payload_length = plen;
        send_request(r);
    endtask

    task automatic send_bytes(input int off, input int count);
        item_t r;
        int    i;
        for (i = 0; i < count; i++) begin
            r           = junk_item();
            r.operation = OP_DATA;
            image[(off + i) & 8'hFF] = r.data_byte;
            send_request(r);
        end
    endtask

    task automatic send_chunk(input logic [7:0] tid, input int off, input int len);
        send_header(tid, 8'(off), 8'(len), hdr_plen(8'(len)));
        send_bytes(off, len);
    endtask

    task automatic send_commit(input logic [7:0] tid, input logic [7:0] len,
                               input logic [15:0] crc, input logic [15:0] plen);
        item_t r;
        r                = junk_item();
        r.operation      = OP_COMMIT;
        r.transaction_id = tid;
        r.length         = len;
        r.target_crc     = crc;
        r.payload_length = plen;
        send_request(r);
    endtask

    task automatic send_read(input int addr);
        item_t r;
        r              = junk_item();
        r.operation    = OP_READ;
        r.start_offset = 8'(addr);
        send_request(r);
    endtask

    task automatic send_other(input logic [2:0] op);
        item_t r;
        r           = junk_item();
        r.operation = op;
        send_request(r);
    endtask

    // One chunked transfer with random content and an occasional flaw
    task automatic run_transfer();
        logic [7:0]  tid;
        logic [15:0] crc;
        int          total;
        int          off;
        int          clen;
        int          roll;
        tid  = 8'($urandom_range(255));
        roll = $urandom_range(99);
        total = (roll < 80) ? $urandom_range(1, 32) :
                (roll < 97) ? $urandom_range(33, 96) : $urandom_range(97, 200);
        off = 0;
        while (off < total) begin
            clen = $urandom_range(1, CHUNK_MAX);
            if (clen > total - off)
                clen = total - off;
            roll = $urandom_range(99);
            send_header(tid, 8'(off), 8'(clen), hdr_plen(8'(clen)));
            if (roll < 6) begin
                // cut the chunk short with a read
                send_bytes(off, $urandom_range(0, clen - 1));
                send_read($urandom_range(LAST_ADDR));
            end else
                send_bytes(off, clen);
            // rewrite the same chunk now and then
            if (roll >= 6 && roll < 14)
                send_chunk(tid, off, clen);
            if ($urandom_range(99) < 8)
                send_read($urandom_range(LAST_ADDR));
            off += clen;
        end

        crc  = image_crc(total);
        roll = $urandom_range(99);
        if (roll < 12)
            send_commit(tid, 8'(total), crc ^ 16'(1 << $urandom_range(15)), COMMIT_PLEN);
        else if (roll < 17)
            send_commit(tid, 8'($urandom_range(255)), crc, COMMIT_PLEN);
        else if (roll < 20)
            send_commit(tid, 8'(total), crc, 16'($urandom_range(65535)));
        else if (roll < 23) begin
            send_commit(tid ^ 8'h01, 8'(total), crc, COMMIT_PLEN);
            send_commit(tid, 8'(total), crc, COMMIT_PLEN);
        end else
            send_commit(tid, 8'(total), crc, COMMIT_PLEN);
    endtask

    // A few unstructured requests
    task automatic run_noise();
        item_t r;
        repeat ($urandom_range(1, 4)) begin
            r = junk_item();
            if ($urandom_range(1))
                r.length = 8'($urandom_range(30));
            if ($urandom_range(1))
                r.start_offset = '0;
            case ($urandom_range(3))
                0: r.payload_length = hdr_plen(r.length);
                1: r.payload_length = COMMIT_PLEN;
                2: r.payload_length = 16'($urandom_range(5));
                default: ;
            endcase
            // never read the one index no chunk can write
            if (r.operation == OP_READ)
                r.start_offset = 8'($urandom_range(LAST_ADDR));
            send_request(r);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int target;
        int roll;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        target        = sent_count + count;
        while (sent_count < target) begin
            roll = $urandom_range(99);
            if (roll < 65)
                run_transfer();
            else if (roll < 80)
                repeat ($urandom_range(1, 3)) send_read($urandom_range(LAST_ADDR));
            else
                run_noise();
        end
    endtask

    initial begin
        int off;
        int len;
        int phase_reqs;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every reachable index, then commit the longest transfer
        off = 0;
        while (off <= LAST_ADDR) begin
            len = (LAST_ADDR + 1 - off < CHUNK_MAX) ? LAST_ADDR + 1 - off : CHUNK_MAX;
            send_chunk(8'h3C, off, len);
            off += len;
        end
        send_commit(8'h3C, 8'd255, image_crc(255), COMMIT_PLEN);

        // Header checks: short payload, bad length, bad bounds, denied start
        send_header(8'h10, 8'd0, 8'd4, 16'd0);
        send_header(8'h10, 8'd0, 8'd4, 16'd2);
        send_header(8'h10, 8'd0, 8'd0, hdr_plen(8'd0));
        send_header(8'h10, 8'd0, 8'd25, hdr_plen(8'd25));
        send_header(8'h10, 8'd0, 8'd5, 16'hFFFF);
        send_header(8'h10, 8'd232, 8'd24, hdr_plen(8'd24));
        send_header(8'h42, 8'd8, 8'd4, hdr_plen(8'd4));

        // Open a stage, cut the chunk short, send a stray byte
        send_header(8'hFF, 8'd0, 8'd24, hdr_plen(8'd24));
        send_bytes(0, 3);
        send_read(0);
        send_bytes(200, 1);

        // Commit checks: bad payload, wrong tag, missing bytes, zero length
        send_commit(8'hFF, 8'd24, 16'h0000, 16'd3);
        send_commit(8'h00, 8'd24, 16'h0000, COMMIT_PLEN);
        send_commit(8'hFF, 8'd24, 16'h0000, COMMIT_PLEN);
        send_chunk(8'h00, 0, 1);
        send_commit(8'h00, 8'd0, 16'hFFFF, COMMIT_PLEN);
        send_commit(8'h00, 8'd1, 16'hFFFF, COMMIT_PLEN);

        // CRC mismatch, then a clean short transfer
        send_chunk(8'h00, 0, 2);
        send_commit(8'h00, 8'd2, ~image_crc(2), COMMIT_PLEN);
        send_chunk(8'h81, 0, 2);
        send_commit(8'h81, 8'd2, image_crc(2), COMMIT_PLEN);

        // Reads at the top index and the middle, other commands
        send_read(LAST_ADDR);
        send_read(128);
        send_other(OP_OTHER);
        send_other(3'd7);
        wait_idle();

        // Split what is left of the request budget over the idle patterns
        phase_reqs = (sent_count < ITEM_TARGET) ? (ITEM_TARGET - sent_count) / 4 : 1;
        if (phase_reqs < 1)
            phase_reqs = 1;

        // Random traffic under each idle pattern
        run_phase(0, 0, phase_reqs);
        wait_idle();
        run_phase(81, 0, phase_reqs);
        wait_idle();
        run_phase(0, 81, phase_reqs);
        wait_idle();
        run_phase(19, 19, phase_reqs);
        wait_idle();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
